// ===== sv/tlbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbq_pkg: shared types and constants for the broadcast queue
// Status codes, opcodes, fixed field widths and the per-cell control struct.
// ----------------------------------------------------------------------------
package tlbq_pkg;

  // Fixed field widths
  localparam int SEND_W    = 8;
  localparam int SEQ_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_KEY_W = 16;
  localparam int LIMIT_W   = 8;

  // Transmit limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;

  // Opcodes
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED_NEW   = 3'd0,
    ST_REPLACED     = 3'd1,
    ST_POPPED_KEPT  = 3'd2,
    ST_POPPED_RETIR = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_FULL_REJECT  = 3'd5
  } status_t;

  // Per-cell control: rotate one place along the ring, or load a new entry
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== sv/transmit_limited_broadcast_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transmit_limited_broadcast_queue: gossip broadcast queue with send limit
// Push/pop queue of keyed entries held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: in_opcode
//   selects push of in_item_key or pop of the next entry. Every transaction
//   yields exactly one result on the output channel (out_valid/out_ready):
//   out_status, out_key and out_occupancy after the operation.
//   cfg_wr_en/cfg_wr_data write the transmit limit; write it only while idle.
// Operation:
//   After acceptance the ring rotates once through all DEPTH cells so each
//   entry passes the head cell once (key match, free slot, best pop
//   candidate), then the apply step writes the chosen cell and loads the
//   result register. The scan examines one entry per cycle, and a new
//   transaction is taken only after the previous one has been applied.
// Reset:
//   rst_n (synchronous, active low) empties the queue, zeroes the sequence
//   counter and sets the transmit limit to 3.
// Stall:
//   The result register holds while out_ready is low; the next transaction
//   is still accepted and scanned, and waits in the apply step until the
//   result register frees up.
// ----------------------------------------------------------------------------
module transmit_limited_broadcast_queue #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [KEY_BITS-1:0]                 in_item_key,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tlbq_pkg::STATUS_W-1:0]       out_status,
  output logic [tlbq_pkg::OUT_KEY_W-1:0]      out_key,
  output logic [$clog2(DEPTH+1)-1:0]          out_occupancy,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [tlbq_pkg::LIMIT_W-1:0]        cfg_wr_data
);
  import tlbq_pkg::*;

  localparam int IDXW  = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH+1);
  localparam logic [IDXW-1:0]  LAST_STEP = IDXW'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  // ring of cells
  logic                cell_valid [DEPTH];
  logic [KEY_BITS-1:0] cell_key   [DEPTH];
  logic [SEND_W-1:0]   cell_sends [DEPTH];
  logic [SEQ_W-1:0]    cell_seq   [DEPTH];
  logic [DEPTH-1:0]    valid_vec;

  // control state
  state_t              state_r;
  logic [IDXW-1:0]     step_r;
  opcode_t             op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [SEQ_W-1:0]    seq_cnt_r;
  logic [OCC_W-1:0]    occ_r;

  // scan results
  logic                hit_r;
  logic [IDXW-1:0]     hit_idx_r;
  logic                free_r;
  logic [IDXW-1:0]     free_idx_r;
  logic                best_r;
  logic [IDXW-1:0]     best_idx_r;
  logic [KEY_BITS-1:0] best_key_r;
  logic [SEND_W-1:0]   best_sends_r;
  logic [SEQ_W-1:0]    best_seq_r;

  // result register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [OUT_KEY_W-1:0] out_key_r;
  logic [OCC_W-1:0]     out_occ_r;

  // apply-step decisions
  logic                 apply_go;
  logic                 store;
  logic [IDXW-1:0]      tgt_idx;
  logic                 ld_valid;
  logic [KEY_BITS-1:0]  ld_key;
  logic [SEND_W-1:0]    ld_sends;
  logic [SEQ_W-1:0]     ld_seq;
  logic [SEQ_W-1:0]     seq_cnt_nxt;
  logic [OCC_W-1:0]     occ_nxt;
  status_t              status_nxt;
  logic [OUT_KEY_W-1:0] okey_nxt;
  logic [SEND_W:0]      sends_inc;
  logic                 head_better;
  logic                 scanning;

  assign scanning = (state_r == S_SCAN);

  // cell instances; cell j takes from cell j+1, the last from cell 0
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    localparam int NB = (j + 1) % DEPTH;
    cell_ctl_t ctl;

    assign ctl = '{shift: scanning,
                   load:  (apply_go && store && (tgt_idx == IDXW'(j)))};

    tlbq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl),
      .nb_valid_i (cell_valid[NB]),
      .nb_key_i   (cell_key[NB]),
      .nb_sends_i (cell_sends[NB]),
      .nb_seq_i   (cell_seq[NB]),
      .ld_valid_i (ld_valid),
      .ld_key_i   (ld_key),
      .ld_sends_i (ld_sends),
      .ld_seq_i   (ld_seq),
      .valid_o    (cell_valid[j]),
      .key_o      (cell_key[j]),
      .sends_o    (cell_sends[j]),
      .seq_o      (cell_seq[j])
    );

    assign valid_vec[j] = cell_valid[j];
  end

  // head cell vs. current pop candidate: fewer sends, then newer id
  assign head_better = cell_valid[0] &&
                       (!best_r ||
                        (cell_sends[0] < best_sends_r) ||
                        ((cell_sends[0] == best_sends_r) && (cell_seq[0] > best_seq_r)));

  // apply step: pick the target cell, new entry and result
  always_comb begin
    store       = 1'b0;
    tgt_idx     = '0;
    ld_valid    = 1'b1;
    ld_key      = key_r;
    ld_sends    = '0;
    ld_seq      = seq_cnt_r + 1'b1;
    seq_cnt_nxt = seq_cnt_r;
    occ_nxt     = occ_r;
    status_nxt  = ST_EMPTY;
    okey_nxt    = '0;
    sends_inc   = {1'b0, best_sends_r} + 1'b1;
    case (op_r)
      OP_PUSH: begin
        if (hit_r) begin
          store       = 1'b1;
          tgt_idx     = hit_idx_r;
          seq_cnt_nxt = seq_cnt_r + 1'b1;
          status_nxt  = ST_REPLACED;
        end else if (free_r) begin
          store       = 1'b1;
          tgt_idx     = free_idx_r;
          seq_cnt_nxt = seq_cnt_r + 1'b1;
          occ_nxt     = occ_r + 1'b1;
          status_nxt  = ST_PUSHED_NEW;
        end else begin
          status_nxt  = ST_FULL_REJECT;
        end
      end
      OP_POP: begin
        if (best_r) begin
          store    = 1'b1;
          tgt_idx  = best_idx_r;
          ld_key   = best_key_r;
          ld_sends = sends_inc[SEND_W-1:0];
          ld_seq   = best_seq_r;
          okey_nxt = OUT_KEY_W'(best_key_r);
          if (sends_inc >= {1'b0, limit_r}) begin
            ld_valid   = 1'b0;
            occ_nxt    = occ_r - 1'b1;
            status_nxt = ST_POPPED_RETIR;
          end else begin
            status_nxt = ST_POPPED_KEPT;
          end
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      default: begin
        status_nxt = ST_EMPTY;
      end
    endcase
  end

  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // transmit limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // sequencer: state, scan trackers, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      op_r         <= OP_PUSH;
      key_r        <= '0;
      seq_cnt_r    <= '0;
      occ_r        <= '0;
      hit_r        <= 1'b0;
      hit_idx_r    <= '0;
      free_r       <= 1'b0;
      free_idx_r   <= '0;
      best_r       <= 1'b0;
      best_idx_r   <= '0;
      best_key_r   <= '0;
      best_sends_r <= '0;
      best_seq_r   <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= '0;
      out_key_r    <= '0;
      out_occ_r    <= '0;
    end else begin
      // result valid: set on apply, cleared once taken
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= opcode_t'(in_opcode);
            key_r   <= in_item_key;
            step_r  <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            best_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // head cell holds slot step_r this cycle
          if (cell_valid[0] && !hit_r && (cell_key[0] == key_r)) begin
            hit_r     <= 1'b1;
            hit_idx_r <= step_r;
          end
          if (!cell_valid[0] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= step_r;
          end
          if (head_better) begin
            best_r       <= 1'b1;
            best_idx_r   <= step_r;
            best_key_r   <= cell_key[0];
            best_sends_r <= cell_sends[0];
            best_seq_r   <= cell_seq[0];
          end
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            seq_cnt_r    <= seq_cnt_nxt;
            occ_r        <= occ_nxt;
            out_status_r <= status_nxt;
            out_key_r    <= okey_nxt;
            out_occ_r    <= occ_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_occupancy = out_occ_r;

  // occupancy count tracks the valid bits in the ring
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy counter out of step with valid bits");

  // never more entries than cells
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("occupancy above depth");

  // a rejected push only happens with every cell occupied
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && (status_nxt == ST_FULL_REJECT)) |-> (occ_r == OCC_FULL))
    else $error("push rejected while a slot was free");

  // retiring a popped entry drops occupancy by one
  a_retire_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && (status_nxt == ST_POPPED_RETIR)) |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("retire did not reduce occupancy");

  // ring scan advances one slot per cycle
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (scanning && (step_r != LAST_STEP)) |=> (scanning && (step_r == $past(step_r) + 1'b1)))
    else $error("scan step skipped or stopped early");

endmodule

// ===== sv/tlbq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbq_cell: one queue entry in the rotating ring
// Holds valid, key, transmit count and sequence id. On shift it takes the
// entry of its neighbor; on load it takes the entry written by the control.
// ----------------------------------------------------------------------------
module tlbq_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlbq_pkg::cell_ctl_t        ctl_i,
  // neighbor entry
  input  logic                       nb_valid_i,
  input  logic [KEY_BITS-1:0]        nb_key_i,
  input  logic [tlbq_pkg::SEND_W-1:0] nb_sends_i,
  input  logic [tlbq_pkg::SEQ_W-1:0] nb_seq_i,
  // load entry
  input  logic                       ld_valid_i,
  input  logic [KEY_BITS-1:0]        ld_key_i,
  input  logic [tlbq_pkg::SEND_W-1:0] ld_sends_i,
  input  logic [tlbq_pkg::SEQ_W-1:0] ld_seq_i,
  // held entry
  output logic                       valid_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [tlbq_pkg::SEND_W-1:0] sends_o,
  output logic [tlbq_pkg::SEQ_W-1:0] seq_o
);
  import tlbq_pkg::*;

  logic                valid_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SEND_W-1:0]   sends_r;
  logic [SEQ_W-1:0]    seq_r;

  // valid bit: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.load) begin
      valid_r <= ld_valid_i;
    end else if (ctl_i.shift) begin
      valid_r <= nb_valid_i;
    end
  end

  // payload: only meaningful while valid
  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      key_r   <= ld_key_i;
      sends_r <= ld_sends_i;
      seq_r   <= ld_seq_i;
    end else if (ctl_i.shift) begin
      key_r   <= nb_key_i;
      sends_r <= nb_sends_i;
      seq_r   <= nb_seq_i;
    end
  end

  assign valid_o = valid_r;
  assign key_o   = key_r;
  assign sends_o = sends_r;
  assign seq_o   = seq_r;

endmodule
